FILE: hdl/wsp_pkg.sv
package wsp_pkg;

    // Defaults for the top-level parameters
    localparam int SCREEN_WIDTH_DEF  = 1024;
    localparam int SCREEN_HEIGHT_DEF = 768;
    localparam int FRAC_BITS_DEF     = 16;

    // Register file and config port
    localparam int NUM_PAIRS = 8;
    localparam int PAIR_IW   = $clog2(NUM_PAIRS);
    localparam int CFG_IDX_W = 8;

    // NDC clamp is +-2^45, which needs 47 bits signed
    localparam int NDC_LIMIT_LOG2 = 45;
    localparam int NDC_W          = NDC_LIMIT_LOG2 + 2;

    typedef logic signed [31:0] q_t;
    typedef logic [63:0] pair_t;
    typedef logic [NUM_PAIRS-1:0][63:0] mat_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // Control and status that ride alongside the divider pipeline
    typedef struct packed {
        logic valid;
        logic zero_w;
        logic neg_x;
        logic neg_y;
        logic zero_x;
        logic zero_y;
        logic in_front;
        q_t   depth;
    } side_t;

    // Element e of the column-major matrix
    function automatic q_t mat_elem(mat_t m, int unsigned e);
        pair_t p;
        p = m[e >> 1];
        return (e % 2 == 1) ? q_t'(p[63:32]) : q_t'(p[31:0]);
    endfunction

endpackage

FILE: hdl/wsp_if.sv
interface wsp_point_if;
    import wsp_pkg::*;
    logic valid;
    logic ready;
    q_t   world_x;
    q_t   world_y;
    q_t   world_z;
    modport source (output valid, output world_x, output world_y, output world_z,
                    input ready);
    modport sink   (input valid, input world_x, input world_y, input world_z,
                    output ready);
endinterface

interface wsp_screen_if;
    import wsp_pkg::*;
    logic valid;
    logic ready;
    q_t   screen_x;
    q_t   screen_y;
    q_t   depth_w;
    logic in_front;
    modport source (output valid, output screen_x, output screen_y, output depth_w,
                    output in_front, input ready);
    modport sink   (input valid, input screen_x, input screen_y, input depth_w,
                    input in_front, output ready);
endinterface

interface wsp_cfg_if;
    import wsp_pkg::*;
    logic     valid;
    logic     ready;
    cfg_idx_t index;
    pair_t    data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/world_to_screen_projection.sv
// World-to-screen perspective projection.
// point  : sink channel, one world point (x, y, z, signed fixed point) per transfer.
// screen : source channel, one result per point: screen x/y in pixels, clip w as
//          depth_w and the in_front flag (w >= 0.1). Results keep input order.
// cfg    : write channel for the eight 64-bit matrix pair registers, always ready;
//          indexes past the last register are dropped. Write only while idle.
// The bit-per-stage divider for x/w and y/w makes up most of the pipeline depth.
// Throughput: one point per cycle while the receiver takes results; the whole
// pipeline advances in lockstep.
// When the receiver stalls, the final register holds its result and the whole
// pipeline freezes, point.ready drops, and nothing is lost or repeated.
// Reset clears all stage valid bits and loads the identity matrix.
module world_to_screen_projection #(
    parameter int SCREEN_WIDTH  = wsp_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = wsp_pkg::SCREEN_HEIGHT_DEF,
    parameter int FRAC_BITS     = wsp_pkg::FRAC_BITS_DEF
) (
    input  logic   clk,
    input  logic   rst_n,
    wsp_point_if.sink    point,
    wsp_screen_if.source screen,
    wsp_cfg_if.sink      cfg
);
    import wsp_pkg::*;

    localparam int DW = 32 + FRAC_BITS;
    localparam int MW = NDC_W + 15;
    localparam logic signed [65:0] OFF_X = 66'(SCREEN_WIDTH) <<< (FRAC_BITS - 1);
    localparam logic signed [65:0] OFF_Y = 66'(SCREEN_HEIGHT) <<< (FRAC_BITS - 1);
    localparam int THRESH = ((1 << FRAC_BITS) + 5) / 10;
    localparam logic [63:0] NDC_LIM = 64'(1) << NDC_LIMIT_LOG2;
    localparam pair_t ONE_LO = pair_t'(64'(1) << FRAC_BITS);
    localparam pair_t ONE_HI = pair_t'(64'(1) << (FRAC_BITS + 32));
    localparam mat_t  MAT_IDENT = {ONE_HI, 64'd0, ONE_LO, 64'd0,
                                   64'd0, ONE_HI, 64'd0, ONE_LO};

    function automatic q_t sat32(logic signed [65:0] v);
        if (v > 66'sh0_7FFF_FFFF)
            return q_t'(32'h7FFF_FFFF);
        if (v < -66'sh0_8000_0000)
            return q_t'(32'h8000_0000);
        return q_t'(v[31:0]);
    endfunction

    logic advance;
    assign advance     = !screen.valid || screen.ready;
    assign point.ready = advance;
    assign cfg.ready   = 1'b1;

    // Matrix registers
    mat_t mat_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg <= MAT_IDENT;
        end
        else if (cfg.valid && cfg.index < CFG_IDX_W'(NUM_PAIRS))
        begin
            mat_reg[cfg.index[PAIR_IW-1:0]] <= cfg.data;
        end
    end

    // Stage 1: nine products plus translation for rows x, y, w
    logic signed [63:0] prod_reg [3][3];
    q_t                 tr_reg   [3];
    logic               v1_reg;
    q_t                 pt       [3];
    assign pt[0] = point.world_x;
    assign pt[1] = point.world_y;
    assign pt[2] = point.world_z;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int r = 0; r < 3; r++)
            begin
                int unsigned row;
                row = (r == 2) ? 3 : r;
                for (int c = 0; c < 3; c++)
                    prod_reg[r][c] <= 64'(pt[c]) * 64'(mat_elem(mat_reg, c * 4 + row));
                tr_reg[r] <= mat_elem(mat_reg, 12 + row);
            end
        end
    end

    // Stage 2: floor the sums to fixed point and saturate
    q_t   clip_reg [3];
    logic front_reg;
    logic v2_reg;
    q_t   clip_next[3];
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            logic signed [65:0] sum;
            sum = 66'(prod_reg[r][0]) + 66'(prod_reg[r][1]) + 66'(prod_reg[r][2])
                + (66'(tr_reg[r]) <<< FRAC_BITS);
            clip_next[r] = sat32(sum >>> FRAC_BITS);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            clip_reg  <= clip_next;
            front_reg <= clip_next[2] >= q_t'(THRESH);
        end
    end

    // Stage 3: magnitudes and signs for the dividers
    logic [DW-1:0] numx_reg, numy_reg;
    logic [31:0]   den_reg;
    side_t         s3_reg;
    logic          v3_reg;
    logic [31:0]   absx, absy, absw;
    assign absx = clip_reg[0][31] ? 32'(~clip_reg[0] + 32'd1) : 32'(clip_reg[0]);
    assign absy = clip_reg[1][31] ? 32'(~clip_reg[1] + 32'd1) : 32'(clip_reg[1]);
    assign absw = clip_reg[2][31] ? 32'(~clip_reg[2] + 32'd1) : 32'(clip_reg[2]);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            numx_reg        <= {absx, FRAC_BITS'(0)};
            numy_reg        <= {absy, FRAC_BITS'(0)};
            den_reg         <= absw;
            s3_reg.zero_w   <= clip_reg[2] == '0;
            s3_reg.neg_x    <= clip_reg[0][31] ^ clip_reg[2][31];
            s3_reg.neg_y    <= clip_reg[1][31] ^ clip_reg[2][31];
            s3_reg.zero_x   <= clip_reg[0] == '0;
            s3_reg.zero_y   <= clip_reg[1] == '0;
            s3_reg.in_front <= front_reg;
            s3_reg.depth    <= clip_reg[2];
            s3_reg.valid    <= 1'b0;
        end
    end

    // Dividers for x/w and y/w
    logic [DW-1:0] qx, qy;
    wsp_div #(.DW(DW)) u_div_x (.clk(clk), .en(advance), .num(numx_reg), .den(den_reg),
                                .quot(qx));
    wsp_div #(.DW(DW)) u_div_y (.clk(clk), .en(advance), .num(numy_reg), .den(den_reg),
                                .quot(qy));

    // Sideband delay line matching the divider
    side_t side_reg [DW];
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < DW; k++)
                side_reg[k] <= (k == 0) ? s3_reg : side_reg[k-1];
        end
    end

    // Valid bits for every stage
    logic [DW-1:0] vd_reg;
    logic v4_reg, v5_reg, v6_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vd_reg <= '0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= point.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            vd_reg <= {vd_reg[DW-2:0], v3_reg};
            v4_reg <= vd_reg[DW-1];
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // Stage 4: clamp, zero-w override, apply sign
    side_t side_out;
    assign side_out = side_reg[DW-1];
    logic signed [NDC_W-1:0] nx_reg, ny_reg;
    side_t s4_reg, s5_reg;
    logic [63:0] magx, magy;
    always_comb
    begin
        if (side_out.zero_w)
        begin
            magx = side_out.zero_x ? 64'd0 : NDC_LIM;
            magy = side_out.zero_y ? 64'd0 : NDC_LIM;
        end
        else
        begin
            magx = (64'(qx) > NDC_LIM) ? NDC_LIM : 64'(qx);
            magy = (64'(qy) > NDC_LIM) ? NDC_LIM : 64'(qy);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            nx_reg <= side_out.neg_x ? -$signed(NDC_W'(magx)) : $signed(NDC_W'(magx));
            ny_reg <= side_out.neg_y ? -$signed(NDC_W'(magy)) : $signed(NDC_W'(magy));
            s4_reg <= side_out;
        end
    end

    // Stage 5: scale by the viewport size
    logic signed [MW-1:0] mx_reg, my_reg;
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mx_reg <= MW'(nx_reg) * MW'($signed({1'b0, 14'(SCREEN_WIDTH)}));
            my_reg <= MW'(ny_reg) * MW'($signed({1'b0, 14'(SCREEN_HEIGHT)}));
            s5_reg <= s4_reg;
        end
    end

    // Stage 6: halve, offset, saturate into the output register
    q_t   sx_reg, sy_reg, dw_reg;
    logic fr_reg;
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sx_reg <= sat32((66'(mx_reg) >>> 1) + OFF_X);
            sy_reg <= sat32(OFF_Y - (66'(my_reg) >>> 1));
            dw_reg <= s5_reg.depth;
            fr_reg <= s5_reg.in_front;
        end
    end

    assign screen.valid    = v6_reg;
    assign screen.screen_x = sx_reg;
    assign screen.screen_y = sy_reg;
    assign screen.depth_w  = dw_reg;
    assign screen.in_front = fr_reg;

    // Checks
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        screen.valid && !screen.ready |-> !point.ready)
        else $error("input taken while output stalled");
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        point.valid && point.ready |=> v1_reg)
        else $error("accepted point lost at stage 1");
    a_front_pos: assert property (@(posedge clk) disable iff (!rst_n)
        screen.valid && screen.in_front |-> !screen.depth_w[31])
        else $error("in_front with negative depth");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        screen.valid && !screen.ready |=> screen.valid && $stable(screen.screen_x))
        else $error("stalled result changed");

endmodule

FILE: hdl/wsp_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
module wsp_div #(
    parameter int DW = 48
) (
    input  logic          clk,
    input  logic          en,
    input  logic [DW-1:0] num,
    input  logic [31:0]   den,
    output logic [DW-1:0] quot
);
    // a holds the numerator bits still to shift in, quotient bits fill from the bottom
    logic [DW-1:0] a_reg   [DW];
    logic [31:0]   rem_reg [DW];
    logic [31:0]   d_reg   [DW];
    logic [DW-1:0] a_next  [DW];
    logic [31:0]   rem_next[DW];

    always_comb
    begin
        for (int k = 0; k < DW; k++)
        begin
            logic [DW-1:0] a_in;
            logic [31:0]   r_in;
            logic [31:0]   d_in;
            logic [32:0]   trial;
            a_in  = (k == 0) ? num : a_reg[k-1];
            r_in  = (k == 0) ? 32'd0 : rem_reg[k-1];
            d_in  = (k == 0) ? den : d_reg[k-1];
            trial = {r_in, a_in[DW-1]};
            if (trial >= {1'b0, d_in})
            begin
                rem_next[k] = 32'(trial - {1'b0, d_in});
                a_next[k]   = {a_in[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = trial[31:0];
                a_next[k]   = {a_in[DW-2:0], 1'b0};
            end
        end
    end

    // Advance all stages together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DW; k++)
            begin
                a_reg[k]   <= a_next[k];
                rem_reg[k] <= rem_next[k];
                d_reg[k]   <= (k == 0) ? den : d_reg[k-1];
            end
        end
    end

    assign quot = a_reg[DW-1];

endmodule

FILE: tb/wsp_checker.sv
module wsp_checker (
    input  logic         clk,
    input  logic         rst_n,
    wsp_point_if         pt_mon,
    wsp_screen_if        scr_mon,
    wsp_cfg_if           cfg_mon,
    output int           fail_count,
    output int           pending
);
    import wsp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  FB      = FRAC_BITS_DEF;
    localparam int  SW      = SCREEN_WIDTH_DEF;
    localparam int  SH      = SCREEN_HEIGHT_DEF;
    localparam longint NDC_MAX = longint'(1) <<< NDC_LIMIT_LOG2;

    typedef struct {
        q_t   sx;
        q_t   sy;
        q_t   w;
        logic front;
    } pixel_t;

    pair_t  mat_regs [NUM_PAIRS];
    pixel_t expected_pixels [$];
    int     mismatches;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint coeff(int e);
        pair_t p;
        p = mat_regs[e >> 1];
        return (e % 2 == 1) ? longint'($signed(p[63:32])) : longint'($signed(p[31:0]));
    endfunction

    // Exact sum of products plus translation, floored and saturated;
    // integer and fraction parts are summed apart to stay inside 64 bits
    function automatic longint clip_value(longint px, longint py, longint pz, int row);
        longint pts [3];
        longint p, hi, hi_sum, lo_sum;
        pts[0] = px;
        pts[1] = py;
        pts[2] = pz;
        hi_sum = coeff(12 + row);
        lo_sum = 0;
        for (int c = 0; c < 3; c++)
        begin
            p = pts[c] * coeff(c * 4 + row);
            hi = floor_shift(p, FB);
            hi_sum += hi;
            lo_sum += p - (hi <<< FB);
        end
        return clamp32(hi_sum + floor_shift(lo_sum, FB));
    endfunction

    function automatic longint ndc_value(longint c, longint w);
        longint q;
        if (w == 0)
            return (c > 0) ? NDC_MAX : (c < 0) ? -NDC_MAX : 0;
        q = (c <<< FB) / w;
        if (q > NDC_MAX) q = NDC_MAX;
        if (q < -NDC_MAX) q = -NDC_MAX;
        return q;
    endfunction

    function automatic pixel_t project_point(q_t x, q_t y, q_t z);
        pixel_t r;
        longint cx, cy, cw, nx, ny;
        cx = clip_value(x, y, z, 0);
        cy = clip_value(x, y, z, 1);
        cw = clip_value(x, y, z, 3);
        nx = ndc_value(cx, cw);
        ny = ndc_value(cy, cw);
        r.sx = q_t'(clamp32(floor_shift(nx * SW, 1) + (longint'(SW) <<< FB) / 2));
        r.sy = q_t'(clamp32(-floor_shift(ny * SH, 1) + (longint'(SH) <<< FB) / 2));
        r.w = q_t'(cw);
        r.front = (cw >= ((longint'(1) <<< FB) + 5) / 10);
        return r;
    endfunction

    assign fail_count = mismatches;

    // Track register writes, predict on point transfers, compare on screen transfers
    always @(posedge clk or negedge rst_n)
    begin
        pixel_t e;
        if (!rst_n)
        begin
            foreach (mat_regs[i]) mat_regs[i] = '0;
            mat_regs[0] = 64'h10000;
            mat_regs[2] = 64'h10000 << 32;
            mat_regs[5] = 64'h10000;
            mat_regs[7] = 64'h10000 << 32;
            expected_pixels.delete();
            mismatches = 0;
            pending = 0;
        end
        else
        begin
            if (scr_mon.valid && scr_mon.ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transfer: x=%0d y=%0d w=%0d f=%0b",
                                 scr_mon.screen_x, scr_mon.screen_y,
                                 scr_mon.depth_w, scr_mon.in_front);
                end
                else
                begin
                    e = expected_pixels.pop_front();
                    if (e.sx !== scr_mon.screen_x || e.sy !== scr_mon.screen_y ||
                        e.w !== scr_mon.depth_w || e.front !== scr_mon.in_front)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp x=%0d y=%0d w=%0d f=%0b",
                                      " got x=%0d y=%0d w=%0d f=%0b"},
                                     e.sx, e.sy, e.w, e.front, scr_mon.screen_x,
                                     scr_mon.screen_y, scr_mon.depth_w, scr_mon.in_front);
                    end
                end
            end
            if (pt_mon.valid && pt_mon.ready)
                expected_pixels.insert(expected_pixels.size(),
                                       project_point(pt_mon.world_x, pt_mon.world_y,
                                                     pt_mon.world_z));
            if (cfg_mon.valid && cfg_mon.ready && cfg_mon.index < NUM_PAIRS)
                mat_regs[cfg_mon.index[PAIR_IW-1:0]] = cfg_mon.data;
            pending = expected_pixels.size();
        end
    end
endmodule

FILE: tb/tb.sv
module tb;
    import wsp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  LATENCY   = 6 + 32 + FRAC_BITS_DEF;
    localparam longint CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    longint cycles;
    bit   rx_hold_done;
    int   points_sent;

    wsp_point_if  point_ch ();
    wsp_screen_if screen_ch ();
    wsp_cfg_if    cfg_ch ();

    world_to_screen_projection dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .point  (point_ch.sink),
        .screen (screen_ch.source),
        .cfg    (cfg_ch.sink)
    );

    wsp_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .pt_mon     (point_ch),
        .scr_mon    (screen_ch),
        .cfg_mon    (cfg_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic q_t pick_coord();
        case ($urandom_range(0, 9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 0;
            3, 4: return q_t'($urandom);
            default: return q_t'($signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000);
        endcase
    endfunction

    // Hold valid across back-to-back writes; the caller drops it after the last one
    task automatic write_pair(input int idx, input pair_t val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= cfg_idx_t'(idx);
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    task automatic send_point(input q_t x, input q_t y, input q_t z);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            point_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        point_ch.valid   <= 1'b1;
        point_ch.world_x <= x;
        point_ch.world_y <= y;
        point_ch.world_z <= z;
        do @(posedge clk); while (!point_ch.ready);
        points_sent++;
    endtask

    task automatic drain();
        point_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic pair_t q_pair(longint lo, longint hi);
        return {hi[31:0], lo[31:0]};
    endfunction

    // Load a random, extreme or random perspective-like matrix, then write one index past the end
    task automatic load_matrix(input int flavor);
        for (int i = 0; i < NUM_PAIRS; i++)
        begin
            pair_t v;
            case (flavor)
                0: v = {$urandom, $urandom};
                1: v = {32'h80000000, 32'h7fffffff};
                default:
                begin
                    v = {q_t'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000),
                         q_t'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000)};
                    if (i == 1) v[63:32] = 0;
                    if (i == 5) v[63:32] = 32'hffff0000;
                    if (i == 7) v[63:32] = 0;
                end
            endcase
            write_pair(i, v);
        end
        write_pair(NUM_PAIRS + $urandom_range(0, 200), {$urandom, $urandom});
        cfg_ch.valid <= 1'b0;
    endtask

    // Stimulus
    initial
    begin
        q_t edge_vals [4];
        edge_vals = '{32'sh7fffffff, 32'sh80000000, 0, 32'sh00010000};
        rst_n = 1'b0;
        point_ch.valid = 1'b0;
        point_ch.world_x = '0;
        point_ch.world_y = '0;
        point_ch.world_z = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        points_sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: identity matrix, w == 1 so points land directly
        for (int i = 0; i < 4; i++)
            send_point(edge_vals[i], edge_vals[(i + 1) % 4], edge_vals[(i + 2) % 4]);
        drain();

        // Directed: w taken from z, covering zero, tiny, threshold and negative w
        write_pair(1, q_pair(0, 0));
        write_pair(5, q_pair(32'h10000, 32'h10000));
        write_pair(7, q_pair(0, 0));
        cfg_ch.valid <= 1'b0;
        send_point(32'h10000, 32'h10000, 0);
        send_point(32'hffff0000, 0, 0);
        send_point(0, 0, 0);
        send_point(32'h10000, 32'h10000, 6554);
        send_point(32'h10000, 32'h10000, 6553);
        send_point(32'h10000, 32'hffff0000, 1);
        send_point(32'h10000, 32'h10000, 32'hffff0000);
        send_point(32'h7fffffff, 32'h80000000, 32'h7fffffff);
        send_point(32'h80000000, 32'h7fffffff, 32'h80000000);
        drain();

        // Directed: extreme matrix
        load_matrix(1);
        for (int i = 0; i < 4; i++)
            send_point(edge_vals[i], edge_vals[3 - i], edge_vals[i]);
        drain();

        // Random phases, each with its own matrix
        for (int ph = 0; ph < 10; ph++)
        begin
            load_matrix((ph % 5 == 4) ? 0 : 2);
            repeat (138) send_point(pick_coord(), pick_coord(), pick_coord());
            drain();
        end

        // Back to identity to end on reset values
        write_pair(0, 64'h10000);
        write_pair(2, 64'h10000 << 32);
        write_pair(5, 64'h10000);
        write_pair(7, 64'h10000 << 32);
        write_pair(1, 0);
        write_pair(3, 0);
        write_pair(4, 0);
        write_pair(6, 0);
        cfg_ch.valid <= 1'b0;
        repeat (20) send_point(pick_coord(), pick_coord(), pick_coord());
        drain();

        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off while points keep coming
    initial
    begin
        int g;
        screen_ch.ready = 1'b0;
        rx_hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!rx_hold_done && points_sent > 300)
            begin
                rx_hold_done = 1'b1;
                screen_ch.ready <= 1'b0;
                for (int c = 0; c < 200; c++) @(posedge clk);
            end
            g = gap_len();
            if (g == 0)
                screen_ch.ready <= 1'b1;
            else
            begin
                screen_ch.ready <= 1'b0;
                repeat (g - 1) @(posedge clk);
            end
        end
    end

    // Cycle limit
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end
endmodule

FILE: sim.f
hdl/wsp_pkg.sv
hdl/wsp_if.sv
hdl/wsp_div.sv
hdl/world_to_screen_projection.sv
tb/wsp_checker.sv
tb/tb.sv
